FILE: src/cartesian_velocity_limiter_unit_assert.svh
// Assertion macros shared by the checker of the velocity limiter.
// Included by bare file name; holds macros only.
`ifndef CARTESIAN_VELOCITY_LIMITER_UNIT_ASSERT_SVH
`define CARTESIAN_VELOCITY_LIMITER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CVL_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CVL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: src/cvl_pkg.sv
// Package of the Cartesian velocity limiter: widths, register indexes and types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package cvl_pkg;
    localparam int FRAC_BITS = 16;
    localparam int VEL_BITS  = 20;
    localparam int CFG_BITS  = 19;
    localparam int MAG_BITS  = VEL_BITS;
    localparam int SUM_BITS  = 2 * MAG_BITS + 2;
    localparam int ROOT_BITS = SUM_BITS / 2;
    localparam int PROD_BITS = MAG_BITS + CFG_BITS;
    localparam int IDX_BITS  = 2;
    localparam int SQRT_CNT_BITS = $clog2(ROOT_BITS + 1);
    localparam int DIV_CNT_BITS  = $clog2(PROD_BITS + 1);

    localparam logic [IDX_BITS-1:0] REG_MAX_LIN_SPEED = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_MAX_ANG_SPEED = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_MAX_LIN_STEP  = 2'd2;
    localparam logic [IDX_BITS-1:0] REG_MAX_ANG_STEP  = 2'd3;

    localparam logic [CFG_BITS-1:0] RST_LIN_SPEED = CFG_BITS'(16384);
    localparam logic [CFG_BITS-1:0] RST_ANG_SPEED = CFG_BITS'(52429);
    localparam logic [CFG_BITS-1:0] RST_LIN_STEP  = CFG_BITS'(655);
    localparam logic [CFG_BITS-1:0] RST_ANG_STEP  = CFG_BITS'(3277);

    typedef logic signed [VEL_BITS-1:0] vel_t;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_SQRT,
        LN_DIV,
        LN_DONE
    } lane_state_t;

    // Control between top level and a lane.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } lane_ctl_t;
endpackage
`default_nettype wire

FILE: src/cvl_lane.sv
// One lane: norm clamp of a three-axis triple with iterative square root and
// a shared restoring divider. Depends on cvl_pkg.
`default_nettype none
module cvl_lane
    import cvl_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire vel_t                v_in [3],
    input  wire logic [CFG_BITS-1:0] limit,
    output lane_ctl_t                ctl,
    output vel_t                     v_out [3]
);
    lane_state_t state_reg, state_next;
    logic [MAG_BITS-1:0]  mag_reg  [3];
    logic                 neg_reg  [3];
    logic [CFG_BITS-1:0]  lim_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [SQRT_CNT_BITS-1:0] scnt_reg;
    logic [1:0]           axis_reg;
    logic [PROD_BITS-1:0] num_reg;
    logic [PROD_BITS-1:0] quo_reg;
    logic [ROOT_BITS:0]   drem_reg;
    logic [DIV_CNT_BITS-1:0] dcnt_reg;
    logic [MAG_BITS-1:0]  res_reg  [3];

    // Squares are registered at the start beat; their sum is formed in the next cycle.
    logic [MAG_BITS-1:0]  mag_in [3];
    logic [SUM_BITS-1:0]  sum_in;
    logic                 over_in;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag_in[k] = v_in[k][VEL_BITS-1] ? MAG_BITS'(-v_in[k]) : MAG_BITS'(v_in[k]);
        end
    end
    logic [2*MAG_BITS-1:0] sq_reg [3];
    logic [2*CFG_BITS-1:0] lsq_reg;
    logic                  sq_valid_reg;
    assign sum_in = SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1]) + SUM_BITS'(sq_reg[2]);
    assign over_in = sum_in > SUM_BITS'(lsq_reg);

    // Square root held as remainder/root pair with separate radicand.
    logic [SUM_BITS-1:0]  rad_reg;
    logic [ROOT_BITS+1:0] srem_reg;
    logic [ROOT_BITS+1:0] srem_new;
    logic [ROOT_BITS+1:0] stry;
    always_comb begin
        srem_new = {srem_reg[ROOT_BITS-1:0], rad_reg[SUM_BITS-1 -: 2]};
        stry     = {root_reg, 2'b01};
    end

    // Divider step: one quotient bit per cycle.
    logic [ROOT_BITS:0] dsh;
    always_comb begin
        dsh = {drem_reg[ROOT_BITS-1:0], num_reg[PROD_BITS-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= LN_IDLE;
            sq_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sq_valid_reg <= start;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            LN_IDLE: if (sq_valid_reg) state_next = over_in ? LN_SQRT : LN_DONE;
            LN_SQRT: if (scnt_reg == SQRT_CNT_BITS'(ROOT_BITS - 1)) state_next = LN_DIV;
            LN_DIV:  if (dcnt_reg == DIV_CNT_BITS'(PROD_BITS - 1) && axis_reg == 2'd2)
                         state_next = LN_DONE;
            LN_DONE: state_next = LN_IDLE;
            default: state_next = LN_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            for (int k = 0; k < 3; k++) begin
                mag_reg[k] <= mag_in[k];
                neg_reg[k] <= v_in[k][VEL_BITS-1];
                sq_reg[k]  <= (2*MAG_BITS)'(mag_in[k]) * (2*MAG_BITS)'(mag_in[k]);
            end
            lim_reg <= limit;
            lsq_reg <= (2*CFG_BITS)'(limit) * (2*CFG_BITS)'(limit);
        end
        if (state_reg == LN_IDLE && sq_valid_reg) begin
            rad_reg   <= sum_in;
            srem_reg  <= '0;
            root_reg  <= '0;
            scnt_reg  <= '0;
            axis_reg  <= '0;
            dcnt_reg  <= '0;
            drem_reg  <= '0;
            num_reg   <= '0;
            for (int k = 0; k < 3; k++) res_reg[k] <= mag_reg[k];
        end
        if (state_reg == LN_SQRT) begin
            rad_reg  <= rad_reg << 2;
            scnt_reg <= scnt_reg + SQRT_CNT_BITS'(1);
            if (srem_new >= stry) begin
                srem_reg <= srem_new - stry;
                root_reg <= {root_reg[ROOT_BITS-2:0], 1'b1};
            end else begin
                srem_reg <= srem_new;
                root_reg <= {root_reg[ROOT_BITS-2:0], 1'b0};
            end
            if (scnt_reg == SQRT_CNT_BITS'(ROOT_BITS - 1)) begin
                num_reg <= PROD_BITS'(mag_reg[0]) * PROD_BITS'(lim_reg);
            end
        end
        if (state_reg == LN_DIV) begin
            if (dcnt_reg == DIV_CNT_BITS'(PROD_BITS - 1)) begin
                res_reg[axis_reg] <= MAG_BITS'({quo_reg[PROD_BITS-2:0],
                                                (dsh >= {1'b0, root_reg})});
                dcnt_reg <= '0;
                drem_reg <= '0;
                axis_reg <= axis_reg + 2'd1;
                if (axis_reg == 2'd0) num_reg <= PROD_BITS'(mag_reg[1]) * PROD_BITS'(lim_reg);
                else                  num_reg <= PROD_BITS'(mag_reg[2]) * PROD_BITS'(lim_reg);
            end else begin
                num_reg  <= num_reg << 1;
                dcnt_reg <= dcnt_reg + DIV_CNT_BITS'(1);
                if (dsh >= {1'b0, root_reg}) begin
                    drem_reg <= dsh - {1'b0, root_reg};
                    quo_reg  <= {quo_reg[PROD_BITS-2:0], 1'b1};
                end else begin
                    drem_reg <= dsh;
                    quo_reg  <= {quo_reg[PROD_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        ctl.start = start;
        ctl.busy  = (state_reg != LN_IDLE) || sq_valid_reg;
        ctl.done  = (state_reg == LN_DONE);
        for (int k = 0; k < 3; k++) begin
            v_out[k] = neg_reg[k] ? -vel_t'(res_reg[k]) : vel_t'(res_reg[k]);
        end
    end
endmodule
`default_nettype wire

FILE: src/cvl_merge.sv
// Merge stage: slew-limits the six lane results against the stored command.
// Depends on cvl_pkg.
`default_nettype none
module cvl_merge
    import cvl_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire vel_t                req [6],
    input  wire logic [CFG_BITS-1:0] lin_step,
    input  wire logic [CFG_BITS-1:0] ang_step,
    output vel_t                     cmd [6]
);
    vel_t prev_reg [6];
    vel_t prev_next [6];
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            logic signed [VEL_BITS+1:0] d, s;
            s = (k < 3) ? (VEL_BITS+2)'(signed'({1'b0, lin_step}))
                        : (VEL_BITS+2)'(signed'({1'b0, ang_step}));
            d = (VEL_BITS+2)'(req[k]) - (VEL_BITS+2)'(prev_reg[k]);
            if (d > s) d = s;
            if (d < -s) d = -s;
            prev_next[k] = VEL_BITS'((VEL_BITS+2)'(prev_reg[k]) + d);
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 6; k++) prev_reg[k] <= '0;
        end else if (load) begin
            for (int k = 0; k < 6; k++) prev_reg[k] <= prev_next[k];
        end
    end
    assign cmd = prev_reg;
endmodule
`default_nettype wire

FILE: src/cartesian_velocity_limiter_unit.sv
// Top level of the Cartesian velocity limiter: stream ports, registers,
// two norm-clamp lanes and the slew merge. Depends on cvl_pkg, cvl_lane, cvl_merge.
//
// Usage: a beat on s_axis carries six velocity components. The linear and the
// angular triple each go to a lane that tests the norm against its limit and,
// when over, scales by limit/norm with a bit-serial square root and a
// restoring divide per axis. The merge stage then slew-limits all six axes
// against the last issued command. Only one beat is in flight at a time and
// a new beat is taken the cycle after the result leaves.
// The result sits in an output register until m_axis_tready; s_axis_tready
// stays low from acceptance until the result beat is taken.
// Reset (aresetn low, synchronous) restores the register defaults, clears the
// stored command to zero and empties the pipeline.
// Configuration writes on cfg_* are always accepted; they are to be made only
// while no beat is in flight.
`default_nettype none
module cartesian_velocity_limiter_unit
    import cvl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // lin_x, lin_y, lin_z, ang_x, ang_y, ang_z from bit 0 up
    input  wire logic [6*VEL_BITS-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // lin_x, lin_y, lin_z, ang_x, ang_y, ang_z from bit 0 up
    output logic [6*VEL_BITS-1:0]      m_axis_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [IDX_BITS-1:0]   cfg_index,
    input  wire logic [CFG_BITS-1:0]   cfg_data
);
    logic [CFG_BITS-1:0] lin_speed_reg, ang_speed_reg, lin_step_reg, ang_step_reg;
    logic busy_reg, outv_reg, merge_reg;
    vel_t vin [6];
    vel_t lane_out [6];
    vel_t cmd [6];
    lane_ctl_t lin_ctl, ang_ctl;
    logic accept, lin_done_reg, ang_done_reg, both_done;

    assign cfg_ready = 1'b1;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !busy_reg;

    always_comb begin
        for (int k = 0; k < 6; k++) vin[k] = s_axis_tdata[k*VEL_BITS +: VEL_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_speed_reg <= RST_LIN_SPEED;
            ang_speed_reg <= RST_ANG_SPEED;
            lin_step_reg  <= RST_LIN_STEP;
            ang_step_reg  <= RST_ANG_STEP;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAX_LIN_SPEED: lin_speed_reg <= cfg_data;
                REG_MAX_ANG_SPEED: ang_speed_reg <= cfg_data;
                REG_MAX_LIN_STEP:  lin_step_reg  <= cfg_data;
                REG_MAX_ANG_STEP:  ang_step_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    cvl_lane u_lin (
        .aclk, .aresetn, .start(accept), .v_in(vin[0:2]), .limit(lin_speed_reg),
        .ctl(lin_ctl), .v_out(lane_out[0:2])
    );
    cvl_lane u_ang (
        .aclk, .aresetn, .start(accept), .v_in(vin[3:5]), .limit(ang_speed_reg),
        .ctl(ang_ctl), .v_out(lane_out[3:5])
    );
    cvl_merge u_merge (
        .aclk, .aresetn, .load(merge_reg), .req(lane_out),
        .lin_step(lin_step_reg), .ang_step(ang_step_reg), .cmd(cmd)
    );

    // Lanes finish at different times; the merge waits for both.
    assign both_done = lin_done_reg && ang_done_reg && !lin_ctl.busy && !ang_ctl.busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; outv_reg <= 1'b0; merge_reg <= 1'b0;
            lin_done_reg <= 1'b0; ang_done_reg <= 1'b0;
        end else begin
            merge_reg <= both_done;
            if (accept) busy_reg <= 1'b1;
            if (both_done) begin
                lin_done_reg <= 1'b0;
                ang_done_reg <= 1'b0;
            end else begin
                if (lin_ctl.done) lin_done_reg <= 1'b1;
                if (ang_ctl.done) ang_done_reg <= 1'b1;
            end
            if (merge_reg) outv_reg <= 1'b1;
            if (outv_reg && m_axis_tready) begin
                outv_reg <= 1'b0;
                busy_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = outv_reg;
    always_comb begin
        for (int k = 0; k < 6; k++) m_axis_tdata[k*VEL_BITS +: VEL_BITS] = cmd[k];
    end

    logic unused_ok;
    assign unused_ok = lin_ctl.start ^ ang_ctl.start;
endmodule
`default_nettype wire

FILE: src/cvl_checker.sv
// Port-level checker for the velocity limiter, bound to the top level.
// Depends on cvl_pkg and the assertion macro header.
`default_nettype none
`include "cartesian_velocity_limiter_unit_assert.svh"
module cvl_checker
    import cvl_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready
);
    `CVL_ASSERT_IMPL(a_one_in_flight, aclk, aresetn, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
    `CVL_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready stayed high after beat")
    `CVL_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
    `CVL_ASSERT_NEXT(a_free_after_out, aclk, aresetn, m_axis_tvalid && m_axis_tready, s_axis_tready, "not ready after result")
endmodule
bind cartesian_velocity_limiter_unit cvl_checker u_cvl_checker (
    .aclk, .aresetn, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready
);
`default_nettype wire

FILE: bench/tb_cartesian_velocity_limiter_unit.sv
// Self-checking bench for the Cartesian velocity limiter: norm clamp and slew limit
// on six axes, checked beat by beat against a predictor held in this file.
// Depends on cvl_pkg and cartesian_velocity_limiter_unit.
`default_nettype none
module tb_cartesian_velocity_limiter_unit;
    import cvl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    typedef logic signed [VEL_BITS-1:0] axes_t [6];

    logic                   aclk;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [6*VEL_BITS-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [6*VEL_BITS-1:0]  m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [IDX_BITS-1:0]    cfg_index;
    logic [CFG_BITS-1:0]    cfg_data;

    // Predictor state: register copies and the last command issued.
    logic [CFG_BITS-1:0]    lin_speed_lim, ang_speed_lim, lin_step_lim, ang_step_lim;
    logic signed [VEL_BITS-1:0] last_cmd [6];
    logic [6*VEL_BITS-1:0]  limited_cmd_q [$];

    int  error_count;
    int  idle_stall_cnt = 0;
    bit  quiet_mode;  // when set, neither side idles

    cartesian_velocity_limiter_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] root_floor(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scales one triple (elements base..base+2) down to the norm limit when over it.
    function automatic void clamp_triple(ref logic signed [63:0] v [6], input int base,
                                         input logic [CFG_BITS-1:0] lim);
        logic [63:0] m [3];
        logic [63:0] sumsq, nrm, q;
        for (int k = 0; k < 3; k++) m[k] = v[base+k] < 0 ? -v[base+k] : v[base+k];
        sumsq = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
        if (sumsq <= 64'(lim) * 64'(lim)) return;
        nrm = root_floor(sumsq);
        for (int k = 0; k < 3; k++) begin
            q = (m[k] * 64'(lim)) / nrm;
            v[base+k] = v[base+k] < 0 ? -$signed(q) : $signed(q);
        end
    endfunction

    // Works out the limited command for one request and advances the stored command.
    function automatic logic [6*VEL_BITS-1:0] limit_command(logic [6*VEL_BITS-1:0] req);
        logic signed [63:0] v [6];
        logic signed [63:0] stp, dlt;
        logic [6*VEL_BITS-1:0] res;
        for (int k = 0; k < 6; k++) v[k] = $signed(req[k*VEL_BITS +: VEL_BITS]);
        clamp_triple(v, 0, lin_speed_lim);
        clamp_triple(v, 3, ang_speed_lim);
        for (int k = 0; k < 6; k++) begin
            stp = k < 3 ? 64'(lin_step_lim) : 64'(ang_step_lim);
            dlt = v[k] - 64'(last_cmd[k]);
            if (dlt > stp) dlt = stp;
            if (dlt < -stp) dlt = -stp;
            last_cmd[k] = VEL_BITS'(64'(last_cmd[k]) + dlt);
            res[k*VEL_BITS +: VEL_BITS] = last_cmd[k];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        $display("ERROR %0t: %s", $realtime, what);
    endtask

    function automatic bit take_gap();
        return !quiet_mode && ($urandom_range(0, 99) < 10);
    endfunction

    // Sends one command beat; the expectation is queued at acceptance.
    task automatic send_command(logic [6*VEL_BITS-1:0] req);
        @(negedge aclk);
        while (take_gap()) @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        do @(posedge aclk); while (!s_axis_tready);
        limited_cmd_q.push_back(limit_command(req));
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (limited_cmd_q.size() != 0) @(negedge aclk);
        repeat (160) @(negedge aclk);
    endtask

    task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MAX_LIN_SPEED: lin_speed_lim = val;
            REG_MAX_ANG_SPEED: ang_speed_lim = val;
            REG_MAX_LIN_STEP:  lin_step_lim  = val;
            REG_MAX_ANG_STEP:  ang_step_lim  = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(logic [CFG_BITS-1:0] ls, logic [CFG_BITS-1:0] as,
                              logic [CFG_BITS-1:0] lt, logic [CFG_BITS-1:0] at);
        drain();
        write_reg(REG_MAX_LIN_SPEED, ls);
        write_reg(REG_MAX_ANG_SPEED, as);
        write_reg(REG_MAX_LIN_STEP, lt);
        write_reg(REG_MAX_ANG_STEP, at);
    endtask

    function automatic logic [6*VEL_BITS-1:0] pack_axes(axes_t a);
        logic [6*VEL_BITS-1:0] d;
        for (int k = 0; k < 6; k++) d[k*VEL_BITS +: VEL_BITS] = a[k];
        return d;
    endfunction

    // A random component: mostly modest speeds so the clamp sits near its limit,
    // sometimes anything the field allows.
    function automatic logic [VEL_BITS-1:0] rand_axis();
        case ($urandom_range(0, 3))
            0: return VEL_BITS'($urandom);
            1: return VEL_BITS'($signed($urandom_range(0, 2*70000)) - 70000);
            2: return VEL_BITS'($signed($urandom_range(0, 2000)) - 1000);
            default: return '0;
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] rand_limit();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return CFG_BITS'($urandom);
            default: return CFG_BITS'($urandom_range(1, 80000));
        endcase
    endfunction

    // Directed: field extremes under the reset limits, then wide open, then zero speed limits, then zero steps.
    task automatic test_directed();
        axes_t a;
        logic [VEL_BITS-1:0] corners [4];
        corners = '{'0, '1, {1'b0, {(VEL_BITS-1){1'b1}}}, {1'b1, {(VEL_BITS-1){1'b0}}}};
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 6; k++) a[k] = corners[i];
            send_command(pack_axes(a));
        end
        // One axis per triple far over its limit, the others zero, so the clamp lands exactly on it.
        a = '{default: '0};
        a[0] = 20'sd200000; a[4] = -20'sd300000;
        send_command(pack_axes(a));
        // Exactly at and just over the linear limit.
        a = '{default: '0};
        a[1] = 20'sd16384; send_command(pack_axes(a));
        a[1] = 20'sd16385; send_command(pack_axes(a));
        set_limits('1, '1, '1, '1);
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 6; k++) a[k] = corners[(i + k) % 4];
            send_command(pack_axes(a));
        end
        set_limits('0, '0, '1, '1);
        for (int k = 0; k < 6; k++) a[k] = 20'sd12345;
        send_command(pack_axes(a));
        a = '{default: '0}; send_command(pack_axes(a));
        // Zero steps hold the previous command whatever is asked.
        set_limits('1, '1, '0, '0);
        for (int k = 0; k < 6; k++) a[k] = corners[3];
        send_command(pack_axes(a));
    endtask

    task automatic test_random(int n_items);
        axes_t a;
        for (int i = 0; i < n_items; i++) begin
            if (i % 150 == 0)
                set_limits(rand_limit(), rand_limit(), rand_limit(), rand_limit());
            quiet_mode = (i >= 300 && i < 420);
            for (int k = 0; k < 6; k++) a[k] = rand_axis();
            send_command(pack_axes(a));
        end
        quiet_mode = 1'b0;
    endtask

    // Result side: random stalls on m_axis_tready, compare at the accepting edge.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_axis_tready <= !take_gap();
        end
    end

    always @(posedge aclk) begin
        logic [6*VEL_BITS-1:0] want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (limited_cmd_q.size() == 0) begin
                report_mismatch("result beat with no command outstanding");
            end else begin
                want = limited_cmd_q.pop_front();
                for (int k = 0; k < 6; k++)
                    if (m_axis_tdata[k*VEL_BITS +: VEL_BITS] != want[k*VEL_BITS +: VEL_BITS])
                        report_mismatch($sformatf("axis %0d got %0d expected %0d", k,
                            $signed(m_axis_tdata[k*VEL_BITS +: VEL_BITS]),
                            $signed(want[k*VEL_BITS +: VEL_BITS])));
            end
        end
    end

    // Watchdog: cycles with no beat on any channel.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready) || !aresetn)
            idle_stall_cnt <= 0;
        else
            idle_stall_cnt <= idle_stall_cnt + 1;
        if (idle_stall_cnt >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        error_count    = 0;
        quiet_mode     = 1'b0;
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_MAX_LIN_SPEED;
        cfg_data       = '0;
        lin_speed_lim  = RST_LIN_SPEED;
        ang_speed_lim  = RST_ANG_SPEED;
        lin_step_lim   = RST_LIN_STEP;
        ang_step_lim   = RST_ANG_STEP;
        for (int k = 0; k < 6; k++) last_cmd[k] = '0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_random(1030);
        drain();

        if (error_count == 0 && limited_cmd_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (limited_cmd_q.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", limited_cmd_q.size()));
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+src
src/cvl_pkg.sv
src/cvl_lane.sv
src/cvl_merge.sv
src/cartesian_velocity_limiter_unit.sv
src/cvl_checker.sv
bench/tb_cartesian_velocity_limiter_unit.sv
